// ===== rtl/core/lsd_radix_sort_32bit_keys_core_assert.svh =====
// assertion macros used by the core datapath
`ifndef LSD_RADIX_SORT_32BIT_KEYS_CORE_ASSERT_SVH
`define LSD_RADIX_SORT_32BIT_KEYS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside of reset
`define LRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define LRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LRS_ASSERT(lbl, prop, msg)
`define LRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/lrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // capacity and derived widths
  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int HIST_W    = CNT_W;

  // record fields
  localparam int KEY_W = 32;
  localparam int PAY_W = 10;

  // radix layout
  localparam int DIGIT_W = 8;
  localparam int BUCKETS = 1 << DIGIT_W;
  localparam int PASSES  = KEY_W / DIGIT_W;
  localparam int PASS_W  = $clog2(PASSES);

  // function codes of an input transaction
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } record_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic out_empty;
    logic out_rec;
    logic rd_src;
    logic rd_fetch;
    logic idx_clr;
    logic idx_inc;
    logic j_inc;
    logic pass_clr;
    logic pass_inc;
    logic sum_clr;
    logic hist_rd_digit;
    logic hist_rd_j;
    logic hist_rd_next;
    logic hist_zero;
    logic hist_sum;
    logic hist_inc;
    logic scat_wr;
    logic set_sorted;
    logic fetch_adv;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;
    logic sorted;
    logic idx_end;
    logic j_last;
    logic pass_last;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "lsd_radix_sort_32bit_keys_core_assert.svh"

module lrs_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lrs_pkg::cmd_t              cmd_i,
  output lrs_pkg::sts_t                   sts_o,
  input  wire logic [lrs_pkg::KEY_W-1:0]  sort_key_i,
  input  wire logic [lrs_pkg::PAY_W-1:0]  payload_in_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [lrs_pkg::KEY_W-1:0]       sorted_key_o,
  output logic [lrs_pkg::PAY_W-1:0]       payload_out_o,
  output logic                            last_item_o,
  output logic                            empty_set_o,
  output logic                            overflowed_o
);

  // record stores: a holds loaded and final data, b is the scratch side
  lrs_pkg::record_t mem_a [lrs_pkg::MAX_ITEMS];
  lrs_pkg::record_t mem_b [lrs_pkg::MAX_ITEMS];
  lrs_pkg::record_t rda_q, rdb_q;

  // digit histogram
  logic [lrs_pkg::HIST_W-1:0] hist_mem [lrs_pkg::BUCKETS];
  logic [lrs_pkg::HIST_W-1:0] hist_rd_q;

  // control state
  logic [lrs_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [lrs_pkg::CNT_W-1:0]   rp_q, rp_d;
  logic                        sorted_q, sorted_d;
  logic                        ovf_q, ovf_d;
  logic [lrs_pkg::CNT_W-1:0]   idx_q;
  logic [lrs_pkg::DIGIT_W-1:0] j_q;
  logic [lrs_pkg::PASS_W-1:0]  pass_q;
  logic [lrs_pkg::HIST_W-1:0]  sum_q;
  logic [lrs_pkg::DIGIT_W-1:0] digit_q;
  logic                        out_valid_q;

  // output register
  logic [lrs_pkg::KEY_W-1:0] out_key_q;
  logic [lrs_pkg::PAY_W-1:0] out_pay_q;
  logic                      out_last_q, out_empty_q, out_ovf_q;

  // combinational
  lrs_pkg::record_t            src_rec, wr_rec;
  logic [lrs_pkg::DIGIT_W-1:0] digit;
  logic                        new_set, room, last;
  logic [lrs_pkg::CNT_W-1:0]   base_cnt;
  logic                        rd_en, we_a, we_b;
  logic [lrs_pkg::IDX_W-1:0]   rd_addr, wr_addr;
  logic                        hist_rd_en, hist_we;
  logic [lrs_pkg::DIGIT_W-1:0] hist_rd_addr, hist_wr_addr;
  logic [lrs_pkg::HIST_W-1:0]  hist_wr_data;

  // source side of the current pass and its digit
  assign src_rec = pass_q[0] ? rdb_q : rda_q;
  assign digit   = src_rec.key[pass_q * lrs_pkg::DIGIT_W +: lrs_pkg::DIGIT_W];

  // load bookkeeping
  assign new_set  = sorted_q | (cnt_q == '0);
  assign base_cnt = new_set ? '0 : cnt_q;
  assign room     = (base_cnt != lrs_pkg::CNT_W'(lrs_pkg::MAX_ITEMS));
  assign last     = ((rp_q + lrs_pkg::CNT_W'(1)) == cnt_q);

  // record store ports
  assign rd_en   = cmd_i.rd_src | cmd_i.rd_fetch;
  assign rd_addr = cmd_i.rd_fetch ? rp_q[lrs_pkg::IDX_W-1:0] : idx_q[lrs_pkg::IDX_W-1:0];
  assign wr_addr = cmd_i.load ? base_cnt[lrs_pkg::IDX_W-1:0]
                              : hist_rd_q[lrs_pkg::IDX_W-1:0];
  assign wr_rec  = cmd_i.load ? lrs_pkg::record_t'{key: sort_key_i, payload: payload_in_i}
                              : src_rec;
  assign we_a    = (cmd_i.load & room) | (cmd_i.scat_wr & pass_q[0]);
  assign we_b    = cmd_i.scat_wr & ~pass_q[0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rda_q <= mem_a[rd_addr];
      rdb_q <= mem_b[rd_addr];
    end
    if (we_a) begin
      mem_a[wr_addr] <= wr_rec;
    end
    if (we_b) begin
      mem_b[wr_addr] <= wr_rec;
    end
  end

  // histogram ports
  assign hist_rd_en   = cmd_i.hist_rd_digit | cmd_i.hist_rd_j | cmd_i.hist_rd_next;
  assign hist_rd_addr = cmd_i.hist_rd_digit ? digit :
                        cmd_i.hist_rd_next  ? j_q + lrs_pkg::DIGIT_W'(1) : j_q;
  assign hist_we      = cmd_i.hist_zero | cmd_i.hist_sum | cmd_i.hist_inc;
  assign hist_wr_addr = cmd_i.hist_inc ? digit_q : j_q;
  assign hist_wr_data = cmd_i.hist_zero ? '0 :
                        cmd_i.hist_sum  ? sum_q : hist_rd_q + lrs_pkg::HIST_W'(1);

  always_ff @(posedge clk_i) begin
    if (hist_rd_en) begin
      hist_rd_q <= hist_mem[hist_rd_addr];
    end
    if (hist_we) begin
      hist_mem[hist_wr_addr] <= hist_wr_data;
    end
    if (cmd_i.hist_rd_digit) begin
      digit_q <= digit;
    end
  end

  // set bookkeeping: count, read pointer, sorted and overflow flags
  always_comb begin
    cnt_d    = cnt_q;
    rp_d     = rp_q;
    sorted_d = sorted_q;
    ovf_d    = ovf_q;
    if (cmd_i.load) begin
      cnt_d = room ? base_cnt + lrs_pkg::CNT_W'(1) : base_cnt;
      if (new_set) begin
        rp_d     = '0;
        sorted_d = 1'b0;
      end
      ovf_d = (ovf_q & ~new_set) | ~room;
    end else if (cmd_i.set_sorted) begin
      sorted_d = 1'b1;
      rp_d     = '0;
    end else if (cmd_i.fetch_adv) begin
      if (last) begin
        cnt_d    = '0;
        rp_d     = '0;
        sorted_d = 1'b0;
      end else begin
        rp_d = rp_q + lrs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rp_q     <= '0;
      sorted_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rp_q     <= rp_d;
      sorted_q <= sorted_d;
      ovf_q    <= ovf_d;
    end
  end

  // sort sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      j_q    <= '0;
      pass_q <= '0;
      sum_q  <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + lrs_pkg::CNT_W'(1);
      end
      if (cmd_i.j_inc) begin
        j_q <= j_q + lrs_pkg::DIGIT_W'(1);
      end
      if (cmd_i.pass_clr) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + lrs_pkg::PASS_W'(1);
      end
      if (cmd_i.sum_clr) begin
        sum_q <= '0;
      end else if (cmd_i.hist_sum) begin
        sum_q <= sum_q + hist_rd_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_empty | cmd_i.out_rec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_empty) begin
      out_key_q   <= '0;
      out_pay_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b1;
      out_ovf_q   <= ovf_q;
    end else if (cmd_i.out_rec) begin
      out_key_q   <= rda_q.key;
      out_pay_q   <= rda_q.payload;
      out_last_q  <= last;
      out_empty_q <= 1'b0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sorted_key_o  = out_key_q;
  assign payload_out_o = out_pay_q;
  assign last_item_o   = out_last_q;
  assign empty_set_o   = out_empty_q;
  assign overflowed_o  = out_ovf_q;

  // status
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.sorted    = sorted_q;
  assign sts_o.idx_end   = (idx_q == cnt_q);
  assign sts_o.j_last    = &j_q;
  assign sts_o.pass_last = (pass_q == lrs_pkg::PASS_W'(lrs_pkg::PASSES - 1));
  assign sts_o.out_full  = out_valid_q;

  // checks
  `LRS_ASSERT(a_cnt_bound, cnt_q <= lrs_pkg::CNT_W'(lrs_pkg::MAX_ITEMS), "item count above capacity")
  `LRS_ASSERT(a_rp_in_set, (cnt_q == '0) || (rp_q < cnt_q), "read pointer outside the set")
  `LRS_ASSERT(a_sorted_nonempty, sorted_q |-> (cnt_q != '0), "sorted flag on an empty set")
  `LRS_ASSERT(a_scatter_pos, cmd_i.scat_wr |-> (hist_rd_q < cnt_q), "scatter position beyond set")
  `LRS_ASSERT(a_out_flags, out_valid_q |-> !(out_last_q && out_empty_q), "last and empty together")

endmodule

`default_nettype wire

// ===== rtl/core/lrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          func_i,
  input  wire logic          out_ready_i,
  input  wire lrs_pkg::sts_t sts_i,
  output lrs_pkg::cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_CLR       = 12'b0000_0000_0010,
    ST_CNT_RD    = 12'b0000_0000_0100,
    ST_CNT_DIG   = 12'b0000_0000_1000,
    ST_CNT_WR    = 12'b0000_0001_0000,
    ST_PFX_START = 12'b0000_0010_0000,
    ST_PFX_STEP  = 12'b0000_0100_0000,
    ST_SCT_RD    = 12'b0000_1000_0000,
    ST_SCT_DIG   = 12'b0001_0000_0000,
    ST_SCT_WR    = 12'b0010_0000_0000,
    ST_FET_RD    = 12'b0100_0000_0000,
    ST_FET_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // input side opens only when idle and the output register can take a result
  assign in_ready_o = (state_q == ST_IDLE) && (!sts_i.out_full || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == lrs_pkg::FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.cnt_zero) begin
            cmd_o.out_empty = 1'b1;
          end else if (!sts_i.sorted) begin
            cmd_o.pass_clr = 1'b1;
            state_d        = ST_CLR;
          end else begin
            state_d = ST_FET_RD;
          end
        end
      end
      ST_CLR: begin
        cmd_o.hist_zero = 1'b1;
        cmd_o.j_inc     = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        if (sts_i.j_last) begin
          state_d = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        cmd_o.rd_src = 1'b1;
        state_d      = ST_CNT_DIG;
      end
      ST_CNT_DIG: begin
        cmd_o.hist_rd_digit = 1'b1;
        cmd_o.idx_inc       = 1'b1;
        state_d             = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd_o.hist_inc = 1'b1;
        if (sts_i.idx_end) begin
          state_d = ST_PFX_START;
        end else begin
          cmd_o.rd_src = 1'b1;
          state_d      = ST_CNT_DIG;
        end
      end
      ST_PFX_START: begin
        cmd_o.hist_rd_j = 1'b1;
        cmd_o.sum_clr   = 1'b1;
        state_d         = ST_PFX_STEP;
      end
      ST_PFX_STEP: begin
        cmd_o.hist_sum     = 1'b1;
        cmd_o.hist_rd_next = 1'b1;
        cmd_o.j_inc        = 1'b1;
        cmd_o.idx_clr      = 1'b1;
        if (sts_i.j_last) begin
          state_d = ST_SCT_RD;
        end
      end
      ST_SCT_RD: begin
        cmd_o.rd_src = 1'b1;
        state_d      = ST_SCT_DIG;
      end
      ST_SCT_DIG: begin
        cmd_o.hist_rd_digit = 1'b1;
        cmd_o.idx_inc       = 1'b1;
        state_d             = ST_SCT_WR;
      end
      ST_SCT_WR: begin
        cmd_o.hist_inc = 1'b1;
        cmd_o.scat_wr  = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.pass_inc = 1'b1;
          if (sts_i.pass_last) begin
            cmd_o.set_sorted = 1'b1;
            state_d          = ST_FET_RD;
          end else begin
            state_d = ST_CLR;
          end
        end else begin
          cmd_o.rd_src = 1'b1;
          state_d      = ST_SCT_DIG;
        end
      end
      ST_FET_RD: begin
        cmd_o.rd_fetch = 1'b1;
        state_d        = ST_FET_OUT;
      end
      ST_FET_OUT: begin
        cmd_o.out_rec   = 1'b1;
        cmd_o.fetch_adv = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lsd_radix_sort_32bit_keys_core.sv =====
// load: accepted when idle, no result; fetch on a sorted set: store read at the read pointer,
// then the record registered into the output, no request taken in between; fetch on an empty
// set: empty result registered from idle; first fetch after loading n records sorts first:
// 4 passes of clear, count, prefix and scatter sweeps over the single-port-pair histogram and
// stores; reset is asynchronous, active low: set empty, flags clear; stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module lsd_radix_sort_32bit_keys_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       func_i,
  input  wire logic [lrs_pkg::KEY_W-1:0]  sort_key_i,
  input  wire logic [lrs_pkg::PAY_W-1:0]  payload_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [lrs_pkg::KEY_W-1:0]       sorted_key_o,
  output logic [lrs_pkg::PAY_W-1:0]       payload_out_o,
  output logic                            last_item_o,
  output logic                            empty_set_o,
  output logic                            overflowed_o
);

  lrs_pkg::cmd_t cmd;
  lrs_pkg::sts_t sts;

  // sequencer
  lrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores, histogram and output register
  lrs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sort_key_i    (sort_key_i),
    .payload_in_i  (payload_in_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .sorted_key_o  (sorted_key_o),
    .payload_out_o (payload_out_o),
    .last_item_o   (last_item_o),
    .empty_set_o   (empty_set_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

`default_nettype wire
